### rtl/rmts_pkg.sv
// Package for the rate-monotonic task scheduler: opcodes, run states, beat structs, FSM states.
// No dependencies.
`default_nettype none
package rmts_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_LOAD     = 3'd1,
        OP_START    = 3'd2,
        OP_DISPATCH = 3'd3,
        OP_COMPLETE = 3'd4
    } opcode_t;

    localparam logic [1:0] ST_BLOCKED = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  task_index;
        logic [31:0] period;
        logic [31:0] rel_deadline;
        logic [31:0] first_release;
        logic        start_ready;
        logic        task_enable;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] selected_task;
        logic       task_found;
        logic       idle_chosen;
        logic       preempt_request;
        logic [3:0] misses_now;
        logic       not_started;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_WB,
        S_RANK_RD,
        S_RANK_CMP,
        S_RANK_WB,
        S_FILL,
        S_LOAD,
        S_PICK,
        S_DISP_WB,
        S_COMPL,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

### rtl/rate_monotonic_task_scheduler_top.sv
// Rate-monotonic task scheduler, top level with the task-record memory and sequencer.
// Depends on rmts_pkg.
//
// Usage: s_ carries one command beat (tick, load, start, dispatch, complete);
// m_ returns exactly one result beat per command, in order.
// Task records (period, deadline, release, timestamps) live in one
// synchronous memory with a registered read port; per-task valid, run state
// and rank and the ready slots stay in flip-flops.
// A tick walks the memory one task at a time (read, then modify and write
// back); the level scan checks one level a cycle; start compares periods one
// pair a cycle.
// One command is in flight at a time; s_ready is low while it works or while
// its result beat waits. When the receiver stalls, the result holds in the
// output register.
// Reset clears valid bits, run states, ranks, slot used bits, current task, the tick
// counter and the started flag. No clearing pass is needed.
`default_nettype none
module rate_monotonic_task_scheduler_top #(
    parameter int NUM_TASKS   = 8,
    parameter int PRIO_LEVELS = 8,
    parameter int TIME_BITS   = 32
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  rmts_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output rmts_pkg::out_beat_t m_data
);
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int LW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int SW = $clog2(PRIO_LEVELS + 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] rel_deadline;
        logic [TIME_BITS-1:0] release_time;
        logic [TIME_BITS-1:0] abs_deadline;
        logic [TIME_BITS-1:0] last_start;
        logic [TIME_BITS-1:0] exec_total;
        logic [31:0]          miss_count;
        logic                 miss_flag;
    } rec_t;

    rec_t mem [NUM_TASKS];
    rec_t rd_reg;
    logic [TW-1:0] rd_addr;
    logic          we;
    logic [TW-1:0] wr_addr;
    rec_t          wr_data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    rmts_pkg::state_t state_reg, state_next;
    rmts_pkg::in_beat_t cmd_reg;
    rmts_pkg::out_beat_t out_reg, out_next;
    logic [NUM_TASKS-1:0] valid_reg, valid_next;
    logic [1:0]    run_reg [NUM_TASKS];
    logic [1:0]    run_next [NUM_TASKS];
    logic [LW-1:0] rank_reg [NUM_TASKS];
    logic [LW-1:0] rank_next [NUM_TASKS];
    logic [PRIO_LEVELS-1:0] used_reg, used_next;
    logic [TW-1:0] slot_reg [PRIO_LEVELS];
    logic [TW-1:0] slot_next [PRIO_LEVELS];
    logic          cur_idle_reg, cur_idle_next;
    logic [TW-1:0] cur_reg, cur_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic          started_reg, started_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [SW-1:0] l_reg, l_next;
    logic [CW-1:0] r_reg, r_next;
    logic [TIME_BITS-1:0] pi_reg, pi_next;
    logic [3:0]    miss_reg, miss_next;

    wire [TW-1:0] i_t = i_reg[TW-1:0];
    wire [TW-1:0] cmd_idx = TW'(cmd_reg.task_index);
    wire          idx_ok = 32'(cmd_reg.task_index) < NUM_TASKS;
    wire [TIME_BITS-1:0] cmd_per = TIME_BITS'(cmd_reg.period);
    wire [TIME_BITS-1:0] cmd_dl = TIME_BITS'(cmd_reg.rel_deadline);
    wire [TIME_BITS-1:0] cmd_fr = TIME_BITS'(cmd_reg.first_release);
    wire [LW-1:0] l_t = l_reg[LW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmts_pkg::S_IDLE;
            valid_reg <= '0;
            used_reg <= '0;
            cur_idle_reg <= 1'b1;
            cur_reg <= '0;
            tick_reg <= '0;
            started_reg <= 1'b0;
            for (int k = 0; k < NUM_TASKS; k++) begin
                run_reg[k] <= rmts_pkg::ST_BLOCKED;
                rank_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            used_reg <= used_next;
            cur_idle_reg <= cur_idle_next;
            cur_reg <= cur_next;
            tick_reg <= tick_next;
            started_reg <= started_next;
            run_reg <= run_next;
            rank_reg <= rank_next;
        end
        slot_reg <= slot_next;
        out_reg <= out_next;
        i_reg <= i_next;
        j_reg <= j_next;
        l_reg <= l_next;
        r_reg <= r_next;
        pi_reg <= pi_next;
        miss_reg <= miss_next;
        if (s_valid && s_ready) begin
            cmd_reg <= s_data;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmts_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (s_data.opcode)
                        rmts_pkg::OP_TICK:     state_next = rmts_pkg::S_TICK_RD;
                        rmts_pkg::OP_LOAD:     state_next = rmts_pkg::S_LOAD;
                        rmts_pkg::OP_START:    state_next = rmts_pkg::S_RANK_RD;
                        rmts_pkg::OP_DISPATCH: state_next = rmts_pkg::S_PICK;
                        rmts_pkg::OP_COMPLETE: state_next = rmts_pkg::S_COMPL;
                        default:               state_next = rmts_pkg::S_OUT;
                    endcase
                end
            end
            rmts_pkg::S_TICK_RD: state_next = rmts_pkg::S_TICK_WB;
            rmts_pkg::S_TICK_WB: begin
                state_next = (32'(i_reg) == NUM_TASKS - 1) ? rmts_pkg::S_PICK
                                                            : rmts_pkg::S_TICK_RD;
            end
            rmts_pkg::S_RANK_RD: begin
                if (32'(i_reg) == NUM_TASKS) begin
                    state_next = rmts_pkg::S_FILL;
                end else if (!valid_reg[i_t]) begin
                    state_next = rmts_pkg::S_RANK_RD;
                end else begin
                    state_next = rmts_pkg::S_RANK_CMP;
                end
            end
            rmts_pkg::S_RANK_CMP: begin
                if (32'(j_reg) == NUM_TASKS) begin
                    state_next = rmts_pkg::S_RANK_WB;
                end
            end
            rmts_pkg::S_RANK_WB: state_next = rmts_pkg::S_RANK_RD;
            rmts_pkg::S_FILL: begin
                if (32'(i_reg) == NUM_TASKS - 1) begin
                    state_next = rmts_pkg::S_OUT;
                end
            end
            rmts_pkg::S_LOAD:  state_next = rmts_pkg::S_OUT;
            rmts_pkg::S_COMPL: state_next = rmts_pkg::S_OUT;
            rmts_pkg::S_PICK: begin
                if (32'(l_reg) == PRIO_LEVELS || used_reg[l_t]) begin
                    if (cmd_reg.opcode == rmts_pkg::OP_DISPATCH && started_reg
                        && 32'(l_reg) != PRIO_LEVELS) begin
                        state_next = rmts_pkg::S_DISP_WB;
                    end else begin
                        state_next = rmts_pkg::S_OUT;
                    end
                end
            end
            rmts_pkg::S_DISP_WB: state_next = rmts_pkg::S_OUT;
            rmts_pkg::S_OUT: begin
                if (m_ready) begin
                    state_next = rmts_pkg::S_IDLE;
                end
            end
            default: state_next = rmts_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [TIME_BITS-1:0] rel;
        logic [TIME_BITS-1:0] pj;
        logic [TW-1:0]        t;
        logic [LW-1:0]        rk;
        rec_t                 rec;
        rel = '0;
        pj = '0;
        t = '0;
        rk = '0;
        rec = rd_reg;
        valid_next = valid_reg;
        run_next = run_reg;
        rank_next = rank_reg;
        used_next = used_reg;
        slot_next = slot_reg;
        cur_idle_next = cur_idle_reg;
        cur_next = cur_reg;
        tick_next = tick_reg;
        started_next = started_reg;
        out_next = out_reg;
        i_next = i_reg;
        j_next = j_reg;
        l_next = l_reg;
        r_next = r_reg;
        pi_next = pi_reg;
        miss_next = miss_reg;
        rd_addr = i_t;
        we = 1'b0;
        wr_addr = i_t;
        wr_data = rd_reg;
        s_ready = (state_reg == rmts_pkg::S_IDLE);
        m_valid = (state_reg == rmts_pkg::S_OUT);
        m_data = out_reg;
        case (state_reg)
            rmts_pkg::S_IDLE: begin
                i_next = '0;
                j_next = '0;
                l_next = '0;
                r_next = '0;
                miss_next = '0;
                out_next = '0;
                rd_addr = '0;
                if (s_valid && s_data.opcode == rmts_pkg::OP_TICK) begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            rmts_pkg::S_TICK_RD: begin
                rd_addr = i_t;
            end
            rmts_pkg::S_TICK_WB: begin
                if (valid_reg[i_t] && run_reg[i_t] == rmts_pkg::ST_RUNNING
                    && tick_reg > rec.abs_deadline) begin
                    rec.miss_count = rec.miss_count + 1'b1;
                    rec.miss_flag = 1'b1;
                    if (miss_reg != 4'hF) begin
                        miss_next = miss_reg + 1'b1;
                    end
                end
                if (valid_reg[i_t] && rec.period != '0 && tick_reg >= rec.release_time) begin
                    if (run_reg[i_t] == rmts_pkg::ST_BLOCKED) begin
                        run_next[i_t] = rmts_pkg::ST_READY;
                        used_next[rank_reg[i_t]] = 1'b1;
                        slot_next[rank_reg[i_t]] = i_t;
                    end
                    if (rec.last_start != '0) begin
                        rec.exec_total = rec.exec_total + (tick_reg - rec.last_start);
                    end
                    rel = tick_reg + rec.period;
                    rec.release_time = rel;
                    rec.abs_deadline = rel + rec.rel_deadline;
                end
                we = valid_reg[i_t];
                wr_data = rec;
                i_next = i_reg + 1'b1;
                rd_addr = TW'(i_reg + 1'b1);
            end
            rmts_pkg::S_RANK_RD: begin
                rd_addr = i_t;
                j_next = '0;
                r_next = '0;
                if (32'(i_reg) == NUM_TASKS) begin
                    i_next = '0;
                    used_next = '0;
                end else if (!valid_reg[i_t]) begin
                    i_next = i_reg + 1'b1;
                end
            end
            rmts_pkg::S_RANK_CMP: begin
                if (32'(j_reg) == 0) begin
                    pi_next = rd_reg.period;
                end
                rd_addr = TW'(j_reg);
                if (32'(j_reg) != 0) begin
                    pj = rd_reg.period;
                    if (32'(j_reg) - 1 != 32'(i_reg) && valid_reg[TW'(j_reg - 1'b1)]
                        && (pj < pi_reg || (pj == pi_reg && j_reg - 1'b1 < i_reg))) begin
                        r_next = r_reg + 1'b1;
                    end
                end
                j_next = j_reg + 1'b1;
            end
            rmts_pkg::S_RANK_WB: begin
                rank_next[i_t] = (32'(r_reg) >= PRIO_LEVELS) ? LW'(PRIO_LEVELS - 1)
                                                              : LW'(r_reg);
                i_next = i_reg + 1'b1;
            end
            rmts_pkg::S_FILL: begin
                if (valid_reg[i_t] && run_reg[i_t] == rmts_pkg::ST_READY) begin
                    used_next[rank_reg[i_t]] = 1'b1;
                    slot_next[rank_reg[i_t]] = i_t;
                end
                started_next = 1'b1;
                i_next = i_reg + 1'b1;
            end
            rmts_pkg::S_LOAD: begin
                if (idx_ok) begin
                    rk = rank_reg[cmd_idx];
                    if (used_reg[rk] && slot_reg[rk] == cmd_idx) begin
                        used_next[rk] = 1'b0;
                    end
                    valid_next[cmd_idx] = cmd_reg.task_enable;
                    run_next[cmd_idx] = cmd_reg.start_ready ? rmts_pkg::ST_READY
                                                           : rmts_pkg::ST_BLOCKED;
                    we = 1'b1;
                    wr_addr = cmd_idx;
                    wr_data.period = cmd_per;
                    wr_data.rel_deadline = cmd_dl;
                    wr_data.release_time = cmd_fr;
                    wr_data.abs_deadline = cmd_fr + cmd_dl;
                    wr_data.last_start = '0;
                    wr_data.exec_total = '0;
                    wr_data.miss_count = '0;
                    wr_data.miss_flag = 1'b0;
                end
            end
            rmts_pkg::S_COMPL: begin
                if (idx_ok) begin
                    rk = rank_reg[cmd_idx];
                    run_next[cmd_idx] = rmts_pkg::ST_BLOCKED;
                    if (used_reg[rk] && slot_reg[rk] == cmd_idx) begin
                        used_next[rk] = 1'b0;
                    end
                    if (!cur_idle_reg && cur_reg == cmd_idx) begin
                        cur_idle_next = 1'b1;
                        cur_next = '0;
                    end
                end
            end
            rmts_pkg::S_PICK: begin
                if (32'(l_reg) == PRIO_LEVELS || used_reg[l_t]) begin
                    t = slot_reg[l_t];
                    rd_addr = t;
                    if (cmd_reg.opcode == rmts_pkg::OP_TICK) begin
                        out_next.misses_now = miss_reg;
                        if (32'(l_reg) != PRIO_LEVELS) begin
                            out_next.selected_task = 3'(t);
                            out_next.task_found = 1'b1;
                            out_next.preempt_request = cur_idle_reg ||
                                (t != cur_reg && rank_reg[t] < rank_reg[cur_reg]);
                        end
                    end else if (!started_reg) begin
                        out_next.not_started = 1'b1;
                    end else if (32'(l_reg) == PRIO_LEVELS) begin
                        cur_idle_next = 1'b1;
                        cur_next = '0;
                        out_next.idle_chosen = 1'b1;
                    end else begin
                        cur_idle_next = 1'b0;
                        cur_next = t;
                        run_next[t] = rmts_pkg::ST_RUNNING;
                        out_next.selected_task = 3'(t);
                        out_next.task_found = 1'b1;
                    end
                end else begin
                    l_next = l_reg + 1'b1;
                end
            end
            rmts_pkg::S_DISP_WB: begin
                we = 1'b1;
                wr_addr = cur_reg;
                wr_data.last_start = tick_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/rmts_checker.sv
// Port-level checker for the scheduler, bound to rate_monotonic_task_scheduler_top.
// Depends on rmts_pkg.
`default_nettype none
module rmts_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input rmts_pkg::in_beat_t  s_data,
    input wire                 m_valid,
    input wire                 m_ready,
    input rmts_pkg::out_beat_t m_data
);
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.idle_chosen || m_data.not_started) |-> !m_data.task_found)
        else $error("idle with task");
    a_pre: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.preempt_request |-> m_data.task_found)
        else $error("preempt without task");
endmodule

bind rate_monotonic_task_scheduler_top rmts_checker u_rmts_checker (.*);
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the rate-monotonic task scheduler: valid/ready driver and monitor,
// a cycle-free predictor of the task table, and random command sessions.
// Depends on rmts_pkg and rate_monotonic_task_scheduler_top.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = 8;
    localparam int NL = 8;
    localparam int IW = $bits(rmts_pkg::in_beat_t);
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int N_RANDOM = 1500;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    rmts_pkg::in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rmts_pkg::out_beat_t m_data;

    rate_monotonic_task_scheduler_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // scheduler mirror
    logic        tv [NT];
    logic [31:0] tper [NT], tdl [NT], trel [NT], tabs [NT], tlast [NT], texec [NT], tmiss [NT];
    logic [1:0]  trun [NT];
    logic [2:0]  trank [NT];
    logic        sused [NL];
    logic [2:0]  stask [NL];
    logic        cur_idle;
    logic [2:0]  cur_task;
    logic [31:0] now_tick;
    logic        is_started;

    rmts_pkg::in_beat_t  cmd_q [$];
    bit                  pause_q [$];
    rmts_pkg::out_beat_t result_q [$];
    int        errors = 0;
    int        n_acc = 0, n_res = 0, n_found = 0, n_preempt = 0, n_miss = 0;
    int        gen_ticks = 0;
    int        n_total = 0;
    bit        quiet_tail = 0;

    function automatic void free_slot(input int t);
        if (sused[trank[t]] && stask[trank[t]] == t) sused[trank[t]] = 1'b0;
    endfunction

    function automatic rmts_pkg::out_beat_t sched_step(input rmts_pkg::in_beat_t b);
        rmts_pkg::out_beat_t o;
        int r, t;
        bit got;
        o = '0;
        got = 0;
        t = 0;
        case (b.opcode)
            rmts_pkg::OP_TICK: begin
                now_tick = now_tick + 1;
                for (int i = 0; i < NT; i++)
                    if (tv[i] && trun[i] == rmts_pkg::ST_RUNNING && now_tick > tabs[i]) begin
                        tmiss[i] = tmiss[i] + 1;
                        if (o.misses_now < 15) o.misses_now = o.misses_now + 4'd1;
                    end
                for (int i = 0; i < NT; i++) begin
                    if (!tv[i] || tper[i] == 0 || now_tick < trel[i]) continue;
                    if (trun[i] == rmts_pkg::ST_BLOCKED) begin
                        trun[i] = rmts_pkg::ST_READY;
                        sused[trank[i]] = 1'b1;
                        stask[trank[i]] = 3'(i);
                    end
                    if (tlast[i] != 0) texec[i] = texec[i] + (now_tick - tlast[i]);
                    trel[i] = now_tick + tper[i];
                    tabs[i] = trel[i] + tdl[i];
                end
                for (int l = NL - 1; l >= 0; l--)
                    if (sused[l]) begin
                        got = 1;
                        t = stask[l];
                    end
                if (got) begin
                    o.selected_task = 3'(t);
                    o.task_found = 1'b1;
                    if (cur_idle || (t != cur_task && trank[t] < trank[cur_task]))
                        o.preempt_request = 1'b1;
                end
            end
            rmts_pkg::OP_LOAD: begin
                t = b.task_index;
                free_slot(t);
                tv[t] = b.task_enable;
                tper[t] = b.period;
                tdl[t] = b.rel_deadline;
                trel[t] = b.first_release;
                tabs[t] = b.first_release + b.rel_deadline;
                trun[t] = b.start_ready ? rmts_pkg::ST_READY : rmts_pkg::ST_BLOCKED;
                tlast[t] = 0;
                texec[t] = 0;
                tmiss[t] = 0;
            end
            rmts_pkg::OP_START: begin
                for (int i = 0; i < NT; i++) begin
                    if (!tv[i]) continue;
                    r = 0;
                    for (int j = 0; j < NT; j++)
                        if (j != i && tv[j] && (tper[j] < tper[i] || (tper[j] == tper[i] && j < i)))
                            r++;
                    trank[i] = 3'((r >= NL) ? NL - 1 : r);
                end
                for (int l = 0; l < NL; l++) sused[l] = 1'b0;
                for (int i = 0; i < NT; i++)
                    if (tv[i] && trun[i] == rmts_pkg::ST_READY) begin
                        sused[trank[i]] = 1'b1;
                        stask[trank[i]] = 3'(i);
                    end
                is_started = 1'b1;
            end
            rmts_pkg::OP_DISPATCH: begin
                for (int l = NL - 1; l >= 0; l--)
                    if (sused[l]) begin
                        got = 1;
                        t = stask[l];
                    end
                if (!is_started) begin
                    o.not_started = 1'b1;
                end else if (got) begin
                    cur_idle = 1'b0;
                    cur_task = 3'(t);
                    trun[t] = rmts_pkg::ST_RUNNING;
                    tlast[t] = now_tick;
                    o.selected_task = 3'(t);
                    o.task_found = 1'b1;
                end else begin
                    cur_idle = 1'b1;
                    cur_task = 0;
                    o.idle_chosen = 1'b1;
                end
            end
            rmts_pkg::OP_COMPLETE: begin
                t = b.task_index;
                trun[t] = rmts_pkg::ST_BLOCKED;
                free_slot(t);
                if (!cur_idle && cur_task == t) begin
                    cur_idle = 1'b1;
                    cur_task = 0;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on result %0d: %s got %0d, expected %0d",
                 $realtime, n_res, what, got, want);
    endtask

    function automatic rmts_pkg::in_beat_t mk(input logic [2:0] op, input int idx = 0,
                                    input logic [31:0] per = 0, input logic [31:0] dl = 0,
                                    input logic [31:0] fr = 0, input bit rdy = 0,
                                    input bit en = 1);
        rmts_pkg::in_beat_t b;
        b.opcode = op;
        b.task_index = 3'(idx);
        b.period = per;
        b.rel_deadline = dl;
        b.first_release = fr;
        b.start_ready = rdy;
        b.task_enable = en;
        return b;
    endfunction

    task automatic push(input rmts_pkg::in_beat_t b, input bit pause = 0);
        if (b.opcode == rmts_pkg::OP_TICK) gen_ticks++;
        cmd_q.push_back(b);
        pause_q.push_back(pause);
        n_total++;
    endtask

    function automatic logic [31:0] rnd_time(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic push_load(input int idx);
        push(mk(rmts_pkg::OP_LOAD, idx, rnd_time(0, 12), rnd_time(0, 15),
                gen_ticks + rnd_time(0, 8), 1'($urandom_range(0, 1)),
                $urandom_range(0, 7) != 0));
    endtask

    task automatic push_noise();
        rmts_pkg::in_beat_t b;
        b = IW'({$urandom(), $urandom(), $urandom(), $urandom()});
        if ($urandom_range(0, 1)) b.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (b.opcode == rmts_pkg::OP_LOAD)
            b.first_release = gen_ticks + $urandom_range(0, 8);
        push(b);
    endtask

    // driver
    bit in_fire, out_fire;
    int in_gap = 0, out_gap = 0, hold_left = 0;
    bit hold_done = 0;

    always @(posedge aclk) begin
        in_fire = aresetn && s_valid && s_ready;
        out_fire = aresetn && m_valid && m_ready;
        if (in_fire) begin
            result_q.push_back(sched_step(s_data));
            n_acc++;
        end
        if (out_fire) begin
            n_res++;
            if (result_q.size() == 0) begin
                report("unexpected beat", 1, 0);
            end else begin
                rmts_pkg::out_beat_t e;
                e = result_q.pop_front();
                if (m_data.selected_task != e.selected_task)
                    report("selected_task", m_data.selected_task, e.selected_task);
                if (m_data.task_found != e.task_found)
                    report("task_found", m_data.task_found, e.task_found);
                if (m_data.idle_chosen != e.idle_chosen)
                    report("idle_chosen", m_data.idle_chosen, e.idle_chosen);
                if (m_data.preempt_request != e.preempt_request)
                    report("preempt_request", m_data.preempt_request, e.preempt_request);
                if (m_data.misses_now != e.misses_now)
                    report("misses_now", m_data.misses_now, e.misses_now);
                if (m_data.not_started != e.not_started)
                    report("not_started", m_data.not_started, e.not_started);
                n_found += e.task_found;
                n_preempt += e.preempt_request;
                n_miss += (e.misses_now != 0);
            end
        end
    end

    always @(negedge aclk) begin
        bit nv;
        rmts_pkg::in_beat_t nd;
        nv = s_valid;
        nd = s_data;
        quiet_tail = n_acc > n_total - 150;
        if (aresetn && (in_fire || !s_valid)) begin
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (cmd_q.size() > 0 &&
                         !(pause_q[0] && (result_q.size() > 0 || s_valid))) begin
                nd = cmd_q.pop_front();
                void'(pause_q.pop_front());
                nv = 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
            end
        end
        s_valid <= nv;
        s_data <= nd;
    end

    always @(negedge aclk) begin
        if (!hold_done && n_acc >= 400) begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
            if (aresetn && !quiet_tail && $urandom_range(0, 5) == 0)
                out_gap = $urandom_range(1, 7);
        end
    end

    initial begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int k, idx;
        for (int i = 0; i < NT; i++) begin
            tv[i] = 0; trun[i] = rmts_pkg::ST_BLOCKED; trank[i] = 0; tabs[i] = 0;
            tlast[i] = 0; texec[i] = 0; tmiss[i] = 0;
            tper[i] = 0; tdl[i] = 0; trel[i] = 0;
        end
        for (int l = 0; l < NL; l++) begin
            sused[l] = 0; stask[l] = 0;
        end
        cur_idle = 1; cur_task = 0; now_tick = 0; is_started = 0;

        // directed opening
        push(mk(rmts_pkg::OP_DISPATCH));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(OP_SPARE_LO, 0, '1, '1, '1, 1, 1));
        push(mk(OP_SPARE_HI));
        push(mk(rmts_pkg::OP_LOAD, 0, 3, 2, 2, 0, 1));
        push(mk(rmts_pkg::OP_LOAD, 7, 3, 0, 0, 1, 1));
        push(mk(rmts_pkg::OP_LOAD, 3, 0, 5, 1, 1, 1));
        push(mk(rmts_pkg::OP_LOAD, 5, '1, '1, '1, 1, 1));
        push(mk(rmts_pkg::OP_LOAD, 6, 2, 1, 3, 0, 0));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(rmts_pkg::OP_START));
        push(mk(rmts_pkg::OP_DISPATCH));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(rmts_pkg::OP_COMPLETE, 7));
        push(mk(rmts_pkg::OP_DISPATCH));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(rmts_pkg::OP_TICK));
        push(mk(rmts_pkg::OP_COMPLETE, 3));
        push(mk(rmts_pkg::OP_COMPLETE, 0));
        push(mk(rmts_pkg::OP_COMPLETE, 5));
        push(mk(rmts_pkg::OP_DISPATCH));
        push(mk(rmts_pkg::OP_START));

        // random sessions: load a table, start, then run it
        while (n_total < N_RANDOM + 25) begin
            k = $urandom_range(1, 8);
            for (int i = 0; i < k; i++) push_load($urandom_range(0, NT - 1));
            push(mk(rmts_pkg::OP_START), n_total > 700 && n_total < 760);
            k = $urandom_range(15, 45);
            for (int i = 0; i < k; i++) begin
                idx = $urandom_range(0, 19);
                if (idx < 8) push(mk(rmts_pkg::OP_TICK));
                else if (idx < 13) push(mk(rmts_pkg::OP_DISPATCH));
                else if (idx < 16)
                    push(mk(rmts_pkg::OP_COMPLETE, $urandom_range(0, NT - 1)));
                else if (idx < 17) push_load($urandom_range(0, NT - 1));
                else if (idx < 18) push(mk(rmts_pkg::OP_START));
                else push_noise();
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait (cmd_q.size() == 0 && !s_valid && result_q.size() == 0);
        repeat (200) @(posedge aclk);
        $display("%0d commands sent, %0d results checked: %0d with a task, %0d preemptions,",
                 n_acc, n_res, n_found, n_preempt);
        $display("%0d ticks with deadline misses, %0d mismatches", n_miss, errors);
        if (errors == 0 && result_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/rmts_pkg.sv
rtl/rate_monotonic_task_scheduler_top.sv
rtl/rmts_checker.sv
bench/tb.sv
